// ----- hdl/pfde_pkg.sv -----
// ----------------------------------------------------------------------------
// pfde_pkg
// types, constants and codes shared by the page frame buffer draw engine
// ----------------------------------------------------------------------------
package pfde_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 128;
  localparam int unsigned SCREEN_HEIGHT_DEF = 64;
  localparam int unsigned STORE_DEPTH       = 1024;
  localparam int unsigned ADDR_W            = 10;

  typedef enum logic [2:0] {
    CMD_PIXEL  = 3'd0,
    CMD_HRUN   = 3'd1,
    CMD_VRUN   = 3'd2,
    CMD_RDPIX  = 3'd3,
    CMD_RDBYTE = 3'd4,
    CMD_CLEAR  = 3'd5,
    CMD_RSV6   = 3'd6,
    CMD_RSV7   = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    INK_CLEAR  = 2'd0,
    INK_SET    = 2'd1,
    INK_INVERT = 2'd2,
    INK_NONE   = 2'd3
  } ink_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_READ,
    ST_WRITE,
    ST_CLEAR,
    ST_RESULT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request and decode
    logic rd;        // issue memory read at current address
    logic wr;        // write modified byte back
    logic step;      // advance run address
    logic clr_init;  // reset sweep address
    logic clr_wr;    // write zero at sweep address
    logic res_load;  // capture result
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic is_write;  // request touches memory with read-modify-write
    logic is_read;   // request returns a result
    logic is_clear;
    logic has_work;  // at least one byte to touch
    logic last;      // current byte is the last one
    logic clr_last;
  } stat_t;

  function automatic logic [7:0] apply_ink(logic [7:0] b, logic [7:0] m, logic [1:0] ink);
    logic [7:0] r;
    r = b;
    unique case (ink)
      INK_SET:    r = b | m;
      INK_CLEAR:  r = b & ~m;
      INK_INVERT: r = b ^ m;
      default:    r = b;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/pfde_datapath.sv -----
// ----------------------------------------------------------------------------
// pfde_datapath
// coordinate mapping, clipping, run stepping and the frame store
// ----------------------------------------------------------------------------
module pfde_datapath #(
  parameter int unsigned SCREEN_WIDTH  = pfde_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = pfde_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pfde_pkg::ctrl_t     ctrl_i,
  output pfde_pkg::stat_t     stat_o,
  input  logic [1:0]          rotation_i,
  input  logic [2:0]          command_i,
  input  logic signed [15:0]  pos_x_i,
  input  logic signed [15:0]  pos_y_i,
  input  logic signed [15:0]  run_length_i,
  input  logic [1:0]          ink_i,
  input  logic [9:0]          byte_index_i,
  output logic                pixel_on_o,
  output logic [7:0]          byte_value_o
);

  localparam int unsigned AW = pfde_pkg::ADDR_W;
  localparam logic signed [19:0] W  = 20'(SCREEN_WIDTH);
  localparam logic signed [19:0] H  = 20'(SCREEN_HEIGHT);

  logic [7:0] mem_q [pfde_pkg::STORE_DEPTH];
  logic [7:0] rdata_q;

  // decoded request, registered
  logic             hor_q, is_w_q, is_r_q, is_c_q, is_byte_q, work_q;
  logic [1:0]       ink_q;
  logic [2:0]       bit_q;
  logic [18:0]      addr_q;   // physical byte address, may exceed store
  logic [18:0]      addr_d;
  logic [18:0]      end_q;    // last address
  logic [7:0]       mask;
  logic [2:0]       lo_q, hi_q;  // vertical run end bits
  logic [18:0]      first_q;
  logic [AW-1:0]    clr_q;
  logic             pix_q;
  logic [7:0]       byte_q;

  // stage 0: map start point to physical run
  logic signed [19:0] x, y, n, lw, lh, px, py, pn;
  logic               phor, in_pt;
  pfde_pkg::cmd_e     cmd;

  always_comb begin
    cmd = pfde_pkg::cmd_e'(command_i);
    x = 20'(pos_x_i);
    y = 20'(pos_y_i);
    n = 20'(run_length_i);
    lw = rotation_i[0] ? H : W;
    lh = rotation_i[0] ? W : H;
    in_pt = (x >= 0) && (x < lw) && (y >= 0) && (y < lh);
    px = x; py = y; pn = n; phor = 1'b1;
    if (cmd == pfde_pkg::CMD_PIXEL || cmd == pfde_pkg::CMD_RDPIX) begin
      pn = 20'sd1;
      unique case (rotation_i)
        2'd1: begin px = W - 20'sd1 - y; py = x; end
        2'd2: begin px = W - 20'sd1 - x; py = H - 20'sd1 - y; end
        2'd3: begin px = y; py = H - 20'sd1 - x; end
        default: begin px = x; py = y; end
      endcase
      if (!in_pt) pn = 20'sd0;
    end else if (cmd == pfde_pkg::CMD_HRUN) begin
      unique case (rotation_i)
        2'd1: begin phor = 1'b0; px = W - 20'sd1 - y; py = x; end
        2'd2: begin px = W - x - n; py = H - 20'sd1 - y; end
        2'd3: begin phor = 1'b0; px = y; py = H - x - n; end
        default: begin px = x; py = y; end
      endcase
    end else begin
      unique case (rotation_i)
        2'd1: begin px = W - y - n; py = x; end
        2'd2: begin phor = 1'b0; px = W - 20'sd1 - x; py = H - y - n; end
        2'd3: begin px = y; py = H - 20'sd1 - x; end
        default: begin phor = 1'b0; px = x; py = y; end
      endcase
    end
  end

  // clip the run to the physical screen
  logic signed [19:0] ax, ay, an, fixed_c, var_s, var_l;
  logic signed [19:0] vs, ve, lim, flim;
  logic               ok;
  always_comb begin
    fixed_c = phor ? py : px;
    flim    = phor ? H : W;
    lim     = phor ? W : H;
    vs      = phor ? px : py;
    ve      = vs + pn - 20'sd1;
    if (vs < 0) vs = 20'sd0;
    if (ve > lim - 20'sd1) ve = lim - 20'sd1;
    ok = (fixed_c >= 0) && (fixed_c < flim) && (pn > 0) && (ve >= vs);
    var_s = vs;
    var_l = ve;
    ax = phor ? vs : fixed_c;
    ay = phor ? fixed_c : vs;
    an = var_l;
  end

  logic [18:0] st_addr, en_addr;
  always_comb begin
    st_addr = 19'(((ay >>> 3) * W) + ax);
    if (phor) en_addr = 19'(((ay >>> 3) * W) + an);
    else      en_addr = 19'(((an >>> 3) * W) + ax);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      is_w_q    <= (cmd == pfde_pkg::CMD_PIXEL) || (cmd == pfde_pkg::CMD_HRUN) ||
                   (cmd == pfde_pkg::CMD_VRUN);
      is_r_q    <= (cmd == pfde_pkg::CMD_RDPIX) || (cmd == pfde_pkg::CMD_RDBYTE);
      is_c_q    <= (cmd == pfde_pkg::CMD_CLEAR);
      is_byte_q <= (cmd == pfde_pkg::CMD_RDBYTE);
      hor_q     <= phor;
      ink_q     <= ink_i;
      bit_q     <= 3'(ay);
      lo_q      <= 3'(var_s);
      hi_q      <= 3'(var_l);
      work_q    <= ok;
      first_q   <= st_addr;
      end_q     <= en_addr;
      addr_q    <= (cmd == pfde_pkg::CMD_RDBYTE) ? 19'(byte_index_i) : st_addr;
    end else if (ctrl_i.step) begin
      addr_q <= addr_d;
    end
  end

  assign addr_d = hor_q ? addr_q + 19'd1 : addr_q + 19'(SCREEN_WIDTH);

  always_comb begin
    logic [7:0] lm, hm;
    lm = (addr_q == first_q) ? (8'hFF << lo_q) : 8'hFF;
    hm = (addr_q == end_q) ? (8'hFF >> (3'd7 - hi_q)) : 8'hFF;
    mask = hor_q ? (8'd1 << bit_q) : (lm & hm);
  end

  logic in_store;
  assign in_store = (addr_q < 19'(pfde_pkg::STORE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) rdata_q <= mem_q[addr_q[AW-1:0]];
    if (ctrl_i.clr_wr) mem_q[clr_q] <= 8'h00;
    else if (ctrl_i.wr && in_store)
      mem_q[addr_q[AW-1:0]] <= pfde_pkg::apply_ink(rdata_q, mask, ink_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (ctrl_i.clr_init) clr_q <= '0;
    else if (ctrl_i.clr_wr) clr_q <= clr_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.res_load) begin
      if (is_byte_q) begin
        pix_q  <= 1'b0;
        byte_q <= rdata_q;
      end else begin
        pix_q  <= work_q && in_store && rdata_q[bit_q];
        byte_q <= 8'h00;
      end
    end
  end

  assign pixel_on_o   = pix_q;
  assign byte_value_o = byte_q;

  always_comb begin
    stat_o.is_write = is_w_q;
    stat_o.is_read  = is_r_q;
    stat_o.is_clear = is_c_q;
    stat_o.has_work = work_q;
    stat_o.last     = (addr_q == end_q);
    stat_o.clr_last = (clr_q == AW'(pfde_pkg::STORE_DEPTH - 1));
  end

endmodule

// ----- hdl/pfde_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfde_ctrl
// sequencer for request decode, read-modify-write, clear and result hand-off
// ----------------------------------------------------------------------------
module pfde_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  pfde_pkg::stat_t  stat_i,
  output pfde_pkg::ctrl_t  ctrl_o
);

  pfde_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= pfde_pkg::ST_CLEAR;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfde_pkg::ST_IDLE:  if (in_valid_i) state_d = pfde_pkg::ST_SETUP;
      pfde_pkg::ST_SETUP: begin
        priority if (stat_i.is_clear) state_d = pfde_pkg::ST_CLEAR;
        else if (stat_i.is_read) state_d = pfde_pkg::ST_READ;
        else if (stat_i.is_write && stat_i.has_work) state_d = pfde_pkg::ST_READ;
        else state_d = pfde_pkg::ST_IDLE;
      end
      pfde_pkg::ST_READ:  state_d = stat_i.is_read ? pfde_pkg::ST_RESULT : pfde_pkg::ST_WRITE;
      pfde_pkg::ST_WRITE: state_d = stat_i.last ? pfde_pkg::ST_IDLE : pfde_pkg::ST_READ;
      pfde_pkg::ST_CLEAR: if (stat_i.clr_last) state_d = pfde_pkg::ST_IDLE;
      pfde_pkg::ST_RESULT: if (out_ready_i) state_d = pfde_pkg::ST_IDLE;
      default: state_d = pfde_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o      = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      pfde_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        ctrl_o.load = in_valid_i;
      end
      pfde_pkg::ST_SETUP: begin
        ctrl_o.rd       = 1'b1;
        ctrl_o.clr_init = stat_i.is_clear;
      end
      pfde_pkg::ST_READ: begin
        // fetch the run byte at the current, possibly stepped, address, or capture a read result
        ctrl_o.rd       = !stat_i.is_read;
        ctrl_o.res_load = stat_i.is_read;
      end
      pfde_pkg::ST_WRITE: begin
        ctrl_o.wr   = 1'b1;
        ctrl_o.step = !stat_i.last;
      end
      pfde_pkg::ST_CLEAR:  ctrl_o.clr_wr = 1'b1;
      pfde_pkg::ST_RESULT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

// ----- hdl/page_framebuffer_draw_engine.sv -----
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine
// paged monochrome frame store with pixel, run, read and clear requests
// ----------------------------------------------------------------------------
// sequence: setup, then for a draw or run a read and a write per byte touched,
// for a read a read step and the result held until taken; one request at a
// time, set by the read-modify-write on the single-port frame store; clear
// sweeps all 1024 bytes. reset: after rst_ni the store is zeroed by that sweep,
// no request is taken until it ends; rotation resets to 0
module page_framebuffer_draw_engine #(
  parameter int unsigned SCREEN_WIDTH  = pfde_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = pfde_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         command_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] run_length_i,
  input  logic [1:0]         ink_i,
  input  logic [9:0]         byte_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               pixel_on_o,
  output logic [7:0]         byte_value_o
);

  logic [1:0]      rotation_q;
  pfde_pkg::ctrl_t ctrl;
  pfde_pkg::stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       rotation_q <= 2'd0;
    else if (cfg_we_i) rotation_q <= cfg_wdata_i;
  end

  pfde_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .ctrl_o(ctrl)
  );

  pfde_datapath #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat), .rotation_i(rotation_q),
    .command_i, .pos_x_i, .pos_y_i, .run_length_i, .ink_i, .byte_index_i,
    .pixel_on_o, .byte_value_o
  );

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  a_wr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.wr && ctrl.clr_wr)) else $error("write during clear");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load |-> in_ready_o) else $error("load without ready");

endmodule

// ----- verif/tb_page_framebuffer_draw_engine.sv -----
// ----------------------------------------------------------------------------
// tb_page_framebuffer_draw_engine
// drives draw, run, read and clear requests under every rotation, keeps a
// model of the paged frame store and checks every read result in order
// ----------------------------------------------------------------------------
module tb_page_framebuffer_draw_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = 128;
  localparam int SH = 64;
  localparam int DEPTH = 1024;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic       pixel_on;
    logic [7:0] byte_value;
  } read_res_t;

  class frame_scoreboard;
    logic [7:0] store [DEPTH];
    logic [1:0] rot;
    read_res_t  pending [$];
    int         errors;

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    function void wipe();
      foreach (store[i]) store[i] = '0;
    endfunction

    function void touch(int addr, logic [7:0] mask, logic [1:0] ink);
      if (addr < 0 || addr >= DEPTH) return;
      case (ink)
        pfde_pkg::INK_SET:    store[addr] = store[addr] | mask;
        pfde_pkg::INK_CLEAR:  store[addr] = store[addr] & ~mask;
        pfde_pkg::INK_INVERT: store[addr] = store[addr] ^ mask;
        default:    ;
      endcase
    endfunction

    function void row_run(int x, int y, int w, logic [1:0] ink);
      if (y < 0 || y >= SH) return;
      if (x < 0) begin
        w = w + x;
        x = 0;
      end
      if (x + w > SW) w = SW - x;
      for (int i = 0; i < w; i++)
        touch((y / 8) * SW + x + i, 8'(1 << (y % 8)), ink);
    endfunction

    function void col_run(int x, int y, int h, logic [1:0] ink);
      int last, lo, hi;
      logic [7:0] mask;
      if (x < 0 || x >= SW) return;
      if (y < 0) begin
        h = h + y;
        y = 0;
      end
      if (y + h > SH) h = SH - y;
      if (h <= 0) return;
      last = y + h - 1;
      for (int p = y / 8; p <= last / 8; p++) begin
        lo = (p * 8 > y) ? 0 : y % 8;
        hi = (p * 8 + 7 < last) ? 7 : last % 8;
        mask = 8'((8'hFF << lo) & (8'hFF >> (7 - hi)));
        touch(p * SW + x, mask, ink);
      end
    endfunction

    // logical point to store address and bit, -1 when off screen
    function int map_point(int x, int y, output int bitpos);
      int lw, lh, px, py;
      lw = rot[0] ? SH : SW;
      lh = rot[0] ? SW : SH;
      bitpos = 0;
      if (x < 0 || x >= lw || y < 0 || y >= lh) return -1;
      case (rot)
        2'd1: begin px = SW - 1 - y; py = x; end
        2'd2: begin px = SW - 1 - x; py = SH - 1 - y; end
        2'd3: begin px = y; py = SH - 1 - x; end
        default: begin px = x; py = y; end
      endcase
      bitpos = py % 8;
      return (py / 8) * SW + px;
    endfunction

    function void note_request(pfde_pkg::cmd_e cmd, int x, int y, int n, logic [1:0] ink,
                               logic [9:0] bidx);
      int addr, b;
      read_res_t r;
      case (cmd)
        pfde_pkg::CMD_PIXEL: begin
          addr = map_point(x, y, b);
          if (addr >= 0) touch(addr, 8'(1 << b), ink);
        end
        pfde_pkg::CMD_HRUN: case (rot)
          2'd0: row_run(x, y, n, ink);
          2'd1: col_run(SW - 1 - y, x, n, ink);
          2'd2: row_run(SW - 1 - x - (n - 1), SH - 1 - y, n, ink);
          default: col_run(y, SH - 1 - x - (n - 1), n, ink);
        endcase
        pfde_pkg::CMD_VRUN: case (rot)
          2'd0: col_run(x, y, n, ink);
          2'd1: row_run(SW - 1 - y - (n - 1), x, n, ink);
          2'd2: col_run(SW - 1 - x, SH - 1 - y - (n - 1), n, ink);
          default: row_run(y, SH - 1 - x, n, ink);
        endcase
        pfde_pkg::CMD_RDPIX: begin
          r.pixel_on = 1'b0;
          r.byte_value = '0;
          addr = map_point(x, y, b);
          if (addr >= 0 && addr < DEPTH) r.pixel_on = store[addr][b];
          pending.push_back(r);
        end
        pfde_pkg::CMD_RDBYTE: begin
          r.pixel_on = 1'b0;
          r.byte_value = store[bidx];
          pending.push_back(r);
        end
        pfde_pkg::CMD_CLEAR: wipe();
        default: ;
      endcase
    endfunction

    task check_result(logic pix, logic [7:0] bv);
      read_res_t e;
      if (pending.size() == 0) begin
        report_mismatch("read result with nothing pending");
        return;
      end
      e = pending.pop_front();
      if (pix !== e.pixel_on)
        report_mismatch($sformatf("pixel_on got %b want %b", pix, e.pixel_on));
      if (bv !== e.byte_value)
        report_mismatch($sformatf("byte_value got %h want %h", bv, e.byte_value));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] command_i = '0;
  logic signed [15:0] pos_x_i = '0, pos_y_i = '0, run_length_i = '0;
  logic [1:0] ink_i = '0;
  logic [9:0] byte_index_i = '0;
  logic out_valid_o, out_ready_i = 1'b0;
  logic pixel_on_o;
  logic [7:0] byte_value_o;

  frame_scoreboard sb = new();
  int  cycle_count = 0;
  bit  calm = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  page_framebuffer_draw_engine u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .command_i(command_i),
    .pos_x_i(pos_x_i), .pos_y_i(pos_y_i), .run_length_i(run_length_i),
    .ink_i(ink_i), .byte_index_i(byte_index_i), .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i), .pixel_on_o(pixel_on_o), .byte_value_o(byte_value_o)
  );

  // request side: model updated on acceptance; results checked when taken
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o)
      sb.note_request(pfde_pkg::cmd_e'(command_i), pos_x_i, pos_y_i, run_length_i, ink_i,
                      byte_index_i);
    if (out_valid_o && out_ready_i) sb.check_result(pixel_on_o, byte_value_o);
  end

  // result side stalls in bursts
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 9);
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout");
      $display("*** FAILED ***");
      $finish;
    end
  end

  // valid stays up after acceptance until the next request or an idle gap
  task automatic send_request(pfde_pkg::cmd_e cmd, int x, int y, int n,
                              pfde_pkg::ink_e ink, int bidx);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    command_i <= cmd;
    pos_x_i <= 16'(x);
    pos_y_i <= 16'(y);
    run_length_i <= 16'(n);
    ink_i <= ink;
    byte_index_i <= 10'(bidx);
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_then_set(logic [1:0] r);
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (1100) @(posedge clk_i);
    cfg_wdata_i <= r;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.rot = r;
  endtask

  function automatic int near_coord(int span);
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 65535) - 32768;
      1: return -int'($urandom_range(1, 20));
      2: return span + int'($urandom_range(0, 20));
      default: return $urandom_range(0, span - 1);
    endcase
  endfunction

  task automatic random_request();
    int c, n;
    pfde_pkg::cmd_e cmd;
    c = $urandom_range(0, 99);
    cmd = c < 25 ? pfde_pkg::CMD_PIXEL : c < 40 ? pfde_pkg::CMD_HRUN :
          c < 55 ? pfde_pkg::CMD_VRUN : c < 75 ? pfde_pkg::CMD_RDPIX :
          c < 93 ? pfde_pkg::CMD_RDBYTE : c < 95 ? pfde_pkg::CMD_CLEAR :
          c < 97 ? pfde_pkg::CMD_RSV6 : pfde_pkg::CMD_RSV7;
    case ($urandom_range(0, 9))
      0: n = $urandom_range(0, 65535) - 32768;
      1: n = -int'($urandom_range(0, 5));
      2: n = $urandom_range(100, 300);
      default: n = $urandom_range(1, 40);
    endcase
    send_request(cmd, near_coord(sb.rot[0] ? SH : SW), near_coord(sb.rot[0] ? SW : SH),
                 n, pfde_pkg::ink_e'($urandom_range(0, 3)), $urandom_range(0, 1023));
  endtask

  initial begin
    sb.rot = 2'd0;
    sb.wipe();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    drain_then_set(2'd3);
    // directed corners and special cases
    send_request(pfde_pkg::CMD_PIXEL, 0, 0, 0, pfde_pkg::INK_SET, 0);
    send_request(pfde_pkg::CMD_PIXEL, 63, 127, 0, pfde_pkg::INK_SET, 0);
    send_request(pfde_pkg::CMD_RDPIX, 0, 0, 0, pfde_pkg::INK_SET, 0);
    send_request(pfde_pkg::CMD_RDPIX, 64, 0, 0, pfde_pkg::INK_SET, 0);
    send_request(pfde_pkg::CMD_HRUN, -5, 3, 40, pfde_pkg::INK_INVERT, 0);
    send_request(pfde_pkg::CMD_VRUN, 2, -32768, 32767, pfde_pkg::INK_SET, 0);
    send_request(pfde_pkg::CMD_HRUN, 32767, -32768, -32768, pfde_pkg::INK_SET, 0);
    send_request(pfde_pkg::CMD_VRUN, 4, 4, 0, pfde_pkg::INK_SET, 0);
    send_request(pfde_pkg::CMD_PIXEL, 5, 5, 0, pfde_pkg::INK_NONE, 0);
    send_request(pfde_pkg::CMD_RSV6, 1, 1, 1, pfde_pkg::INK_SET, 1023);
    send_request(pfde_pkg::CMD_RSV7, -1, -1, -1, pfde_pkg::INK_SET, 0);
    send_request(pfde_pkg::CMD_RDBYTE, 0, 0, 0, pfde_pkg::INK_SET, 1023);
    send_request(pfde_pkg::CMD_RDBYTE, 0, 0, 0, pfde_pkg::INK_SET, 0);
    send_request(pfde_pkg::CMD_VRUN, 10, 3, 20, pfde_pkg::INK_CLEAR, 0);
    send_request(pfde_pkg::CMD_CLEAR, 0, 0, 0, pfde_pkg::INK_SET, 0);
    send_request(pfde_pkg::CMD_RDBYTE, 0, 0, 0, pfde_pkg::INK_SET, 0);
    for (int ph = 0; ph < 8; ph++) begin
      drain_then_set(2'(ph % 4));
      if (ph == 7) calm = 1'b1;
      for (int i = 0; i < 250; i++) random_request();
    end
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
